// ----- sv/frma_pkg.sv -----
`timescale 1ns / 1ps

package frma_pkg;

  // Number of intervals in the averaging window.
  localparam int WINDOW = 100;

  // One frame per millisecond in fixed point with 8 fraction bits (1000 * 256).
  localparam int RATE_ONE = 256000;
  // Largest rate reported.
  localparam int RATE_CAP = 256000;
  // Reset value of the zero-sum rate register (60 fps).
  localparam int MAX_RATE_RESET = 15360;
  // Largest interval kept in the ring.
  localparam int INTERVAL_MAX = 65535;

  // Field widths.
  localparam int STAMP_W = 32;
  localparam int INTERVAL_W = 16;
  localparam int RATE_W = 18;
  localparam int SAMPLES_W = 7;

  // Derived widths.
  localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int TOTAL_W = $clog2(INTERVAL_MAX * WINDOW + 1);
  localparam int NUM_W = $clog2(RATE_ONE * WINDOW + 1);
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int OUT_BITS = INTERVAL_W + RATE_W + SAMPLES_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ----- sv/frame_rate_moving_average.sv -----
`timescale 1ns / 1ps

// Moving-average frame-rate meter.
// Each input item on the s_axis channel is the millisecond tick count at the
// end of a frame. The block forms the interval since the previous item
// (modulo 2^32, saturated to 65535, zero for the first item after reset),
// keeps the last WINDOW intervals in an on-chip ring memory together with a
// running sum and a fill count, and emits one result item per input item on
// the m_axis channel: the interval, the rate 256000*count/sum (frames per
// second with 8 fraction bits, truncated, capped at 1000 fps) and the count.
// When the sum is zero the rate is the value last written on the cfg channel.
// Each item passes in order through a ring read at acceptance, an update
// cycle, the restoring divider at one quotient bit per cycle, and an output
// load. Items are processed one at a time: a new item is not accepted until
// the previous result has been loaded into the output register. A result
// waiting in the output register does not block
// acceptance of the next item; only the load of the following result waits
// for the receiver. Reset (rst, synchronous) clears the sum, count, ring
// position and first-item flag and sets the zero-sum rate to 60 fps; the ring
// memory itself is not cleared since entries are read only after being written.
module frame_rate_moving_average
  import frma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Zero-sum rate register.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_W-1:0]     cfg_data,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [STAMP_W-1:0]    s_axis_tdata,   // [31:0] timestamp_ms
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [15:0] interval_ms,
                                                // [33:16] rate_fixed,
                                                // [40:34] samples_in_window
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state;
  logic [RATE_W-1:0]     max_rate;
  logic [STAMP_W-1:0]    previous_stamp;
  logic                  seen_first;
  logic [RING_AW-1:0]    ring_position;
  logic [FILL_W-1:0]     fill_count;
  logic [TOTAL_W-1:0]    window_total;
  logic [INTERVAL_W-1:0] interval;
  logic [INTERVAL_W-1:0] ring [WINDOW];
  logic [INTERVAL_W-1:0] ring_rd;
  logic [NUM_W-1:0]      quot;
  logic [TOTAL_W-1:0]    rem;
  logic [STEP_W-1:0]     step;

  logic                  in_accept;
  logic [STAMP_W-1:0]    diff;
  logic [INTERVAL_W-1:0] interval_next;
  logic                  ring_full;
  logic [FILL_W-1:0]     fill_count_next;
  logic [TOTAL_W-1:0]    window_total_next;
  logic [RING_AW-1:0]    ring_position_next;
  logic [TOTAL_W:0]      div_shift;
  logic [TOTAL_W:0]      div_trial;
  logic                  div_take;
  logic [RATE_W-1:0]     rate;
  logic                  out_load;

  assign cfg_ready     = !rst;
  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Interval since the previous stamp, saturated.
  always_comb begin
    diff = seen_first ? (s_axis_tdata - previous_stamp) : '0;
    if (diff > STAMP_W'(INTERVAL_MAX)) begin
      interval_next = INTERVAL_W'(INTERVAL_MAX);
    end else begin
      interval_next = diff[INTERVAL_W-1:0];
    end
  end

  // Window bookkeeping for the update cycle.
  always_comb begin
    ring_full = (fill_count == FILL_W'(WINDOW));
    fill_count_next = ring_full ? fill_count : fill_count + 1'b1;
    window_total_next = window_total - (ring_full ? TOTAL_W'(ring_rd) : '0)
                        + TOTAL_W'(interval);
    if (ring_position == RING_AW'(WINDOW - 1)) begin
      ring_position_next = '0;
    end else begin
      ring_position_next = ring_position + 1'b1;
    end
  end

  // One restoring division step.
  always_comb begin
    div_shift = {rem, quot[NUM_W-1]};
    div_trial = div_shift - {1'b0, window_total};
    div_take  = (div_shift >= {1'b0, window_total});
  end

  // Final rate selection.
  always_comb begin
    if (window_total == '0) begin
      rate = max_rate;
    end else if (quot > NUM_W'(RATE_CAP)) begin
      rate = RATE_W'(RATE_CAP);
    end else begin
      rate = RATE_W'(quot);
    end
  end

  assign out_load = (state == ST_FIN) && (!m_axis_tvalid || m_axis_tready);

  // Ring memory: read at accept, write back in the update cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_rd <= ring[ring_position];
    end
    if (state == ST_UPD) begin
      ring[ring_position] <= interval;
    end
  end

  // Zero-sum rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate <= RATE_W'(MAX_RATE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_rate <= cfg_data;
    end
  end

  // Sequencer and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      previous_stamp <= '0;
      seen_first     <= 1'b0;
      ring_position  <= '0;
      fill_count     <= '0;
      window_total   <= '0;
      step           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            previous_stamp <= s_axis_tdata;
            seen_first     <= 1'b1;
            state          <= ST_UPD;
          end
        end
        ST_UPD: begin
          fill_count    <= fill_count_next;
          window_total  <= window_total_next;
          ring_position <= ring_position_next;
          step          <= '0;
          state         <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(NUM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: interval, numerator product and divider registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      interval <= interval_next;
    end
    if (state == ST_UPD) begin
      quot <= NUM_W'(fill_count_next * NUM_W'(RATE_ONE));
      rem  <= '0;
    end else if (state == ST_DIV) begin
      quot <= {quot[NUM_W-2:0], div_take};
      rem  <= div_take ? div_trial[TOTAL_W-1:0] : div_shift[TOTAL_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_DATA_W'({SAMPLES_W'(fill_count), rate, interval});
    end
  end

endmodule
